>>> src/kcl_pkg.sv
package kcl_pkg;

   // Key codes carried in the key field.
   localparam logic [3:0] KEY_STAR    = 4'd10;
   localparam logic [3:0] KEY_CONFIRM = 4'd11;
   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;

   // Lock mode codes.
   localparam logic [1:0] MODE_STANDBY = 2'd0;
   localparam logic [1:0] MODE_ENTRY   = 2'd1;
   localparam logic [1:0] MODE_VIEW    = 2'd2;
   localparam logic [1:0] MODE_RSVD    = 2'd3;

   // Field widths fixed by the interface.
   localparam int CODE_W    = 40;
   localparam int CODE_NIBS = 10;
   localparam int CLEN_W    = 4;
   localparam int LEN_CMP_W = 5;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_UNLOCK_CODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLOCK_LEN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHOTO_CODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PHOTO_LEN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUTDOWN_CODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUTDOWN_LEN  = 3'd5;

   // Configuration values after reset.
   localparam logic [CODE_W-1:0] UNLOCK_CODE_RST   = 40'h0000980665;
   localparam logic [CLEN_W-1:0] UNLOCK_LEN_RST    = 4'd6;
   localparam logic [CODE_W-1:0] PHOTO_CODE_RST    = 40'h7182934650;
   localparam logic [CLEN_W-1:0] PHOTO_LEN_RST     = 4'd10;
   localparam logic [CODE_W-1:0] SHUTDOWN_CODE_RST = 40'h0000000886;
   localparam logic [CLEN_W-1:0] SHUTDOWN_LEN_RST  = 4'd3;

   typedef struct packed {
      logic [3:0] key;
      logic       photo_ok;
   } req_type;

   typedef struct packed {
      logic [1:0]        lock_mode;
      logic              armed_flag;
      logic [3:0]        entry_len;
      logic [CODE_W-1:0] entry_digits;
      logic              unlock_pulse;
      logic              capture_request;
      logic              shutdown_request;
   } rsp_type;

   // Code comparison results handed from the comparators to the update logic.
   typedef struct packed {
      logic unlock;
      logic photo;
      logic shutdown;
   } match_type;

endpackage

>>> src/kcl_codematch.sv
module kcl_codematch #(
   parameter int MAX_DIGITS = 10
) (
   input  logic [4*MAX_DIGITS-1:0]          digits,
   input  logic [$clog2(MAX_DIGITS+1)-1:0]  len,
   input  logic [kcl_pkg::CODE_W-1:0]       code,
   input  logic [kcl_pkg::CLEN_W-1:0]       code_len,
   output logic                             match
);
   import kcl_pkg::*;

   localparam int NIBS = (MAX_DIGITS > CODE_NIBS) ? MAX_DIGITS : CODE_NIBS;

   logic [NIBS-1:0] nib_bad;
   logic [LEN_CMP_W-1:0] code_len_x;
   logic [LEN_CMP_W-1:0] len_x;

   assign code_len_x = LEN_CMP_W'(code_len);
   assign len_x      = LEN_CMP_W'(len);

   // Per-nibble compare; only the nibbles inside the code length count.
   for (genvar i = 0; i < NIBS; i++) begin : g_nib
      logic [3:0] d_nib;
      logic [3:0] c_nib;
      if (i < MAX_DIGITS) begin : g_d
         assign d_nib = digits[4*i +: 4];
      end else begin : g_dz
         assign d_nib = 4'd0;
      end
      if (i < CODE_NIBS) begin : g_c
         assign c_nib = code[4*i +: 4];
      end else begin : g_cz
         assign c_nib = 4'd0;
      end
      assign nib_bad[i] = (LEN_CMP_W'(i) < code_len_x) && (d_nib != c_nib);
   end

   // A code of length zero, or longer than the entry can hold, never matches.
   assign match = (code_len_x != '0) && (code_len_x <= LEN_CMP_W'(MAX_DIGITS)) &&
                  (code_len_x == len_x) && (nib_bad == '0);

endmodule

>>> src/kcl_step.sv
module kcl_step #(
   parameter int MAX_DIGITS = 10
) (
   input  logic [1:0]                       mode,
   input  logic                             armed,
   input  logic [$clog2(MAX_DIGITS+1)-1:0]  len,
   input  logic [4*MAX_DIGITS-1:0]          digits,
   input  kcl_pkg::req_type                 req,
   input  logic [kcl_pkg::CODE_W-1:0]       unlock_code,
   input  logic [kcl_pkg::CLEN_W-1:0]       unlock_len,
   input  logic [kcl_pkg::CODE_W-1:0]       photo_code,
   input  logic [kcl_pkg::CLEN_W-1:0]       photo_len,
   input  logic [kcl_pkg::CODE_W-1:0]       shutdown_code,
   input  logic [kcl_pkg::CLEN_W-1:0]       shutdown_len,
   output logic [1:0]                       mode_nxt,
   output logic                             armed_nxt,
   output logic [$clog2(MAX_DIGITS+1)-1:0]  len_nxt,
   output logic [4*MAX_DIGITS-1:0]          digits_nxt,
   output kcl_pkg::match_type               pulse
);
   import kcl_pkg::*;

   localparam int DIGIT_W = 4 * MAX_DIGITS;
   localparam int LEN_W   = $clog2(MAX_DIGITS + 1);

   match_type hit;

   kcl_codematch #(.MAX_DIGITS(MAX_DIGITS)) u_unlock (
      .digits(digits), .len(len), .code(unlock_code), .code_len(unlock_len),
      .match(hit.unlock)
   );

   kcl_codematch #(.MAX_DIGITS(MAX_DIGITS)) u_photo (
      .digits(digits), .len(len), .code(photo_code), .code_len(photo_len),
      .match(hit.photo)
   );

   kcl_codematch #(.MAX_DIGITS(MAX_DIGITS)) u_shutdown (
      .digits(digits), .len(len), .code(shutdown_code), .code_len(shutdown_len),
      .match(hit.shutdown)
   );

   // Next lock state for one key.
   always_comb begin
      mode_nxt   = mode;
      armed_nxt  = armed;
      len_nxt    = len;
      digits_nxt = digits;
      pulse      = '0;
      case (mode)
         MODE_ENTRY: begin
            if (req.key <= KEY_LAST_DIGIT) begin
               if (len < LEN_W'(MAX_DIGITS)) begin
                  digits_nxt = (digits << 4) | DIGIT_W'(req.key);
                  len_nxt    = len + LEN_W'(1);
               end
            end else if (req.key == KEY_STAR) begin
               if (len != '0) begin
                  digits_nxt = digits >> 4;
                  len_nxt    = len - LEN_W'(1);
               end
            end else if (req.key == KEY_CONFIRM) begin
               pulse      = hit;
               len_nxt    = '0;
               digits_nxt = '0;
               if (hit.photo && req.photo_ok) begin
                  mode_nxt = MODE_VIEW;
               end
            end
         end
         MODE_VIEW: begin
            if (req.key == KEY_STAR) begin
               mode_nxt = MODE_ENTRY;
            end
         end
         default: begin
            // Standby: two stars in a row open code entry.
            mode_nxt = MODE_STANDBY;
            if (req.key == KEY_STAR) begin
               if (!armed) begin
                  armed_nxt = 1'b1;
               end else begin
                  armed_nxt  = 1'b0;
                  mode_nxt   = MODE_ENTRY;
                  len_nxt    = '0;
                  digits_nxt = '0;
               end
            end else begin
               armed_nxt = 1'b0;
            end
         end
      endcase
   end

endmodule

>>> src/keypad_code_lock.sv
// Path: a transaction is held in the input register, then in the result
// register.
// Throughput: one key per cycle while the result side does not stall; the lock state is updated in a single pass.
// Reset: synchronous; standby mode, disarmed, empty entry and the default codes.
module keypad_code_lock #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  kcl_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output kcl_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [kcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kcl_pkg::CODE_W-1:0]       csr_wdata
);
   import kcl_pkg::*;

   localparam int DIGIT_W = 4 * MAX_DIGITS;
   localparam int LEN_W   = $clog2(MAX_DIGITS + 1);

   // Configuration registers.
   logic [CODE_W-1:0] unlock_code_ff, photo_code_ff, shutdown_code_ff;
   logic [CLEN_W-1:0] unlock_len_ff, photo_len_ff, shutdown_len_ff;

   // Input stage, lock state and result register.
   logic               in_valid_ff;
   req_type            in_data_ff;
   logic [1:0]         mode_ff;
   logic               armed_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [DIGIT_W-1:0] digits_ff;
   logic               out_valid_ff;
   rsp_type            out_data_ff;

   logic [1:0]         mode_in;
   logic               armed_in;
   logic [LEN_W-1:0]   len_in;
   logic [DIGIT_W-1:0] digits_in;
   match_type          pulse;
   logic               advance;
   logic               out_free;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_code_ff   <= UNLOCK_CODE_RST;
         unlock_len_ff    <= UNLOCK_LEN_RST;
         photo_code_ff    <= PHOTO_CODE_RST;
         photo_len_ff     <= PHOTO_LEN_RST;
         shutdown_code_ff <= SHUTDOWN_CODE_RST;
         shutdown_len_ff  <= SHUTDOWN_LEN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_UNLOCK_CODE:   unlock_code_ff   <= csr_wdata;
            CSR_UNLOCK_LEN:    unlock_len_ff    <= csr_wdata[CLEN_W-1:0];
            CSR_PHOTO_CODE:    photo_code_ff    <= csr_wdata;
            CSR_PHOTO_LEN:     photo_len_ff     <= csr_wdata[CLEN_W-1:0];
            CSR_SHUTDOWN_CODE: shutdown_code_ff <= csr_wdata;
            CSR_SHUTDOWN_LEN:  shutdown_len_ff  <= csr_wdata[CLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the input stage moves on whenever the result register is free.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   kcl_step #(.MAX_DIGITS(MAX_DIGITS)) u_step (
      .mode(mode_ff), .armed(armed_ff), .len(len_ff), .digits(digits_ff),
      .req(in_data_ff),
      .unlock_code(unlock_code_ff), .unlock_len(unlock_len_ff),
      .photo_code(photo_code_ff), .photo_len(photo_len_ff),
      .shutdown_code(shutdown_code_ff), .shutdown_len(shutdown_len_ff),
      .mode_nxt(mode_in), .armed_nxt(armed_in), .len_nxt(len_in),
      .digits_nxt(digits_in), .pulse(pulse)
   );

   // Lock state advances once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_STANDBY;
         armed_ff  <= 1'b0;
         len_ff    <= '0;
         digits_ff <= '0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         armed_ff  <= armed_in;
         len_ff    <= len_in;
         digits_ff <= digits_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff.lock_mode        <= mode_in;
         out_data_ff.armed_flag       <= armed_in;
         out_data_ff.entry_len        <= 4'(len_in);
         out_data_ff.entry_digits     <= CODE_W'(digits_in);
         out_data_ff.unlock_pulse     <= pulse.unlock;
         out_data_ff.capture_request  <= pulse.photo;
         out_data_ff.shutdown_request <= pulse.shutdown;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Consistency checks on the lock state.
   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_RSVD)
      else $error("lock mode holds the reserved code");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_DIGITS))
      else $error("entry length beyond the maximum");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_ENTRY |-> len_ff == '0 && digits_ff == '0)
      else $error("entry not clear outside code entry");

   a_armed_standby: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> mode_ff == MODE_STANDBY)
      else $error("armed outside standby");

   a_view_exit: assert property (@(posedge clock) disable iff (reset)
      $past(mode_ff) == MODE_VIEW && mode_ff != MODE_VIEW |-> mode_ff == MODE_ENTRY)
      else $error("photo view left to a mode other than code entry");

endmodule

>>> test/keypad_lock_checker.sv
// Watches the key and result channels of the code lock, keeps its own copy of
// the lock state and the configured codes, and compares every result
// transaction with the oldest outstanding prediction.
module keypad_lock_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  kcl_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  kcl_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [kcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kcl_pkg::CODE_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            pending,
   output int                            results_seen,
   output int                            unlock_hits,
   output int                            capture_hits,
   output int                            shutdown_hits,
   output int                            view_entries
);
   import kcl_pkg::*;

   // The block is built with its default entry depth of ten digits.
   localparam int ENTRY_MAX = CODE_NIBS;

   // Predicted lock state.
   logic [1:0]        mode_q;
   logic              armed_q;
   logic [3:0]        len_q;
   logic [CODE_W-1:0] digits_q;

   // Copy of the configured codes.
   logic [CODE_W-1:0] unlock_code_q, photo_code_q, shutdown_code_q;
   logic [CLEN_W-1:0] unlock_len_q, photo_len_q, shutdown_len_q;

   rsp_type expected_results[$];
   int      fails, checked, unl_n, cap_n, shut_n, view_n;

   // A code matches only when its length is usable and equals the entry length.
   function automatic logic code_hit(input logic [CODE_W-1:0] code,
                                     input logic [CLEN_W-1:0] clen);
      logic [63:0] mask;
      if (clen == 0 || clen > ENTRY_MAX || clen != len_q)
         return 1'b0;
      mask = (64'd1 << (4 * clen)) - 64'd1;
      return ((digits_q ^ code) & mask[CODE_W-1:0]) == '0;
   endfunction

   // Advances the predicted state by one key and builds the expected result.
   task automatic apply_key(input req_type k, output rsp_type r);
      logic unl, cap, shut;
      unl  = 1'b0;
      cap  = 1'b0;
      shut = 1'b0;
      case (mode_q)
         MODE_ENTRY: begin
            if (k.key <= KEY_LAST_DIGIT) begin
               if (len_q < ENTRY_MAX) begin
                  digits_q = {digits_q[CODE_W-5:0], k.key};
                  len_q    = len_q + 4'd1;
               end
            end else if (k.key == KEY_STAR) begin
               if (len_q != 0) begin
                  digits_q = digits_q >> 4;
                  len_q    = len_q - 4'd1;
               end
            end else if (k.key == KEY_CONFIRM) begin
               unl  = code_hit(unlock_code_q, unlock_len_q);
               cap  = code_hit(photo_code_q, photo_len_q);
               shut = code_hit(shutdown_code_q, shutdown_len_q);
               if (cap && k.photo_ok) begin
                  mode_q = MODE_VIEW;
                  view_n++;
               end
               len_q    = '0;
               digits_q = '0;
            end
         end
         MODE_VIEW: begin
            if (k.key == KEY_STAR)
               mode_q = MODE_ENTRY;
         end
         default: begin
            // Standby, and the unused mode code treated the same way.
            mode_q = MODE_STANDBY;
            if (k.key == KEY_STAR) begin
               if (!armed_q) begin
                  armed_q = 1'b1;
               end else begin
                  armed_q  = 1'b0;
                  mode_q   = MODE_ENTRY;
                  len_q    = '0;
                  digits_q = '0;
               end
            end else begin
               armed_q = 1'b0;
            end
         end
      endcase
      r.lock_mode        = mode_q;
      r.armed_flag       = armed_q;
      r.entry_len        = len_q;
      r.entry_digits     = digits_q;
      r.unlock_pulse     = unl;
      r.capture_request  = cap;
      r.shutdown_request = shut;
      unl_n  += int'(unl);
      cap_n  += int'(cap);
      shut_n += int'(shut);
   endtask

   function automatic bit results_agree(input rsp_type a, input rsp_type b);
      return a.lock_mode === b.lock_mode && a.armed_flag === b.armed_flag &&
             a.entry_len === b.entry_len && a.entry_digits === b.entry_digits &&
             a.unlock_pulse === b.unlock_pulse &&
             a.capture_request === b.capture_request &&
             a.shutdown_request === b.shutdown_request;
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf({"mode %0d armed %0b len %0d digits %010h ",
                        "unlock %0b capture %0b shutdown %0b"},
                       r.lock_mode, r.armed_flag, r.entry_len, r.entry_digits,
                       r.unlock_pulse, r.capture_request, r.shutdown_request);
   endfunction

   // Everything is sampled at the rising edge, before the edge's updates land.
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         mode_q          = MODE_STANDBY;
         armed_q         = 1'b0;
         len_q           = '0;
         digits_q        = '0;
         unlock_code_q   = UNLOCK_CODE_RST;
         unlock_len_q    = UNLOCK_LEN_RST;
         photo_code_q    = PHOTO_CODE_RST;
         photo_len_q     = PHOTO_LEN_RST;
         shutdown_code_q = SHUTDOWN_CODE_RST;
         shutdown_len_q  = SHUTDOWN_LEN_RST;
         expected_results.delete();
      end else begin
         // Register writes; indexes outside the list are ignored by the block.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_UNLOCK_CODE:   unlock_code_q   = csr_wdata;
               CSR_UNLOCK_LEN:    unlock_len_q    = csr_wdata[CLEN_W-1:0];
               CSR_PHOTO_CODE:    photo_code_q    = csr_wdata;
               CSR_PHOTO_LEN:     photo_len_q     = csr_wdata[CLEN_W-1:0];
               CSR_SHUTDOWN_CODE: shutdown_code_q = csr_wdata;
               CSR_SHUTDOWN_LEN:  shutdown_len_q  = csr_wdata[CLEN_W-1:0];
               default: ;
            endcase
         end

         // Result transaction against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result %0d: %s", checked, describe(rsp_data));
            end else begin
               want = expected_results.pop_front();
               if (!results_agree(want, rsp_data)) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("mismatch on result %0d", checked);
                     $display("  expected %s", describe(want));
                     $display("  actual   %s", describe(rsp_data));
                  end
               end
            end
         end

         // Key transaction: every key yields exactly one result.
         if (req_valid && !req_stall) begin
            apply_key(req_data, want);
            expected_results.push_back(want);
         end
      end
      fail_count    <= fails;
      pending       <= expected_results.size();
      results_seen  <= checked;
      unlock_hits   <= unl_n;
      capture_hits  <= cap_n;
      shutdown_hits <= shut_n;
      view_entries  <= view_n;
   end

endmodule

>>> test/tb_keypad_code_lock.sv
// Drives keys and code settings into the lock, varies the pace on both
// channels and gives the verdict from the checker's failure count.
module tb_keypad_code_lock;
   import kcl_pkg::*;

   localparam logic [3:0]           KEY_OTHER     = 4'd12;
   localparam logic [3:0]           KEY_OTHER_MAX = 4'd15;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 3'd7;
   localparam int UNLOCK         = 0;
   localparam int PHOTO          = 1;
   localparam int SHUTDOWN       = 2;
   localparam int PHASE_KEYS     = 240;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   req_type              req_data  = '0;
   logic                 rsp_stall = 1'b0;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CODE_W-1:0]    csr_wdata = '0;
   logic                 req_stall;
   logic                 rsp_valid;
   rsp_type              rsp_data;

   int fail_count, pending, results_seen;
   int unlock_hits, capture_hits, shutdown_hits, view_entries;

   // Stimulus-side copy of the codes, used to type matching entries.
   logic [CODE_W-1:0] codes [3];
   logic [CLEN_W-1:0] lens [3];
   int keys_sent;
   int settings_used;
   int tx_gap_pct   = 10;
   int rx_stall_pct = 10;
   bit quiet_tail;
   bit hold_go;
   bit hold_done;
   int idle_cycles;

   keypad_code_lock dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   keypad_lock_checker lock_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .results_seen  (results_seen),
      .unlock_hits   (unlock_hits),
      .capture_hits  (capture_hits),
      .shutdown_hits (shutdown_hits),
      .view_entries  (view_entries)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 5;
         default: return 25;
      endcase
   endfunction

   // Ten random decimal digits.
   function automatic logic [CODE_W-1:0] random_digits();
      logic [CODE_W-1:0] code;
      for (int i = 0; i < CODE_NIBS; i++)
         code[4*i +: 4] = 4'($urandom_range(0, 9));
      return code;
   endfunction

   // Offers one key transaction and returns at the edge that accepts it.
   task automatic send_key(input logic [3:0] key, input logic ok);
      req_type item;
      if (keys_sent % 50 == 0) begin
         tx_gap_pct   = pick_rate();
         rx_stall_pct = pick_rate();
      end
      if (!quiet_tail && $urandom_range(0, 99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      item.key      = key;
      item.photo_ok = ok;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      keys_sent++;
   endtask

   // Types the lowest n digits of a code, newest last; with a slip, a stray
   // digit is typed and removed again half way through.
   task automatic type_digits(input logic [CODE_W-1:0] code, input int n, input bit slip);
      logic [3:0] d;
      for (int i = n - 1; i >= 0; i--) begin
         d = (i < CODE_NIBS) ? code[4*i +: 4] : 4'($urandom_range(0, 9));
         if (d > KEY_LAST_DIGIT)
            d = d - 4'd6;
         if (slip && i == n / 2) begin
            send_key(4'($urandom_range(0, 9)), coin());
            send_key(KEY_STAR, coin());
         end
         send_key(d, coin());
      end
   endtask

   // Two stars leave the lock in entry; the entry is then empty when they start from standby or photo view.
   task automatic enter_code(input logic [CODE_W-1:0] code, input int n,
                             input logic ok, input bit slip);
      send_key(KEY_STAR, coin());
      send_key(KEY_STAR, coin());
      type_digits(code, n, slip);
      send_key(KEY_CONFIRM, ok);
   endtask

   // Waits until every predicted result has been delivered.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Rewrites all three codes while the lock is idle. Length writes carry
   // random upper bits, which the block drops.
   task automatic program_codes(input logic [CODE_W-1:0] u, input logic [CLEN_W-1:0] ul,
                                input logic [CODE_W-1:0] p, input logic [CLEN_W-1:0] pl,
                                input logic [CODE_W-1:0] s, input logic [CLEN_W-1:0] sl);
      logic [63:0] noise;
      drain();
      write_reg(CSR_UNLOCK_CODE, u);
      noise = {$urandom, $urandom};
      write_reg(CSR_UNLOCK_LEN, {noise[CODE_W-1:CLEN_W], ul});
      write_reg(CSR_PHOTO_CODE, p);
      noise = {$urandom, $urandom};
      write_reg(CSR_PHOTO_LEN, {noise[CODE_W-1:CLEN_W], pl});
      write_reg(CSR_SHUTDOWN_CODE, s);
      noise = {$urandom, $urandom};
      write_reg(CSR_SHUTDOWN_LEN, {noise[CODE_W-1:CLEN_W], sl});
      noise = {$urandom, $urandom};
      write_reg(CSR_SPARE, noise[CODE_W-1:0]);
      csr_wr_en <= 1'b0;
      codes[UNLOCK]   = u;
      lens[UNLOCK]    = ul;
      codes[PHOTO]    = p;
      lens[PHOTO]     = pl;
      codes[SHUTDOWN] = s;
      lens[SHUTDOWN]  = sl;
      settings_used++;
   endtask

   // Mostly code attempts with the configured codes, some with random content, the rest stray keys.
   task automatic random_phase(input int count);
      int stop;
      int r;
      int sel;
      stop = keys_sent + count;
      while (keys_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 25)
            sel = UNLOCK;
         else if (r < 50)
            sel = PHOTO;
         else if (r < 65)
            sel = SHUTDOWN;
         else
            sel = -1;
         if (r >= 75)
            repeat ($urandom_range(1, 6)) send_key(4'($urandom_range(0, 15)), coin());
         else if (sel >= 0)
            enter_code(codes[sel], int'(lens[sel]), $urandom_range(0, 3) != 0,
                       $urandom_range(0, 4) == 0);
         else
            enter_code(random_digits(), $urandom_range(0, 12), coin(), coin());
      end
   endtask

   // Result side: random stall bursts, and one long hold-off so that the
   // block fills up and pushes back on the key channel.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (!quiet_tail && !reset && $urandom_range(0, 99) < rx_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("keypad_code_lock test failed");
      $finish;
   end

   // Main sequence.
   initial begin
      codes[UNLOCK]   = UNLOCK_CODE_RST;
      lens[UNLOCK]    = UNLOCK_LEN_RST;
      codes[PHOTO]    = PHOTO_CODE_RST;
      lens[PHOTO]     = PHOTO_LEN_RST;
      codes[SHUTDOWN] = SHUTDOWN_CODE_RST;
      lens[SHUTDOWN]  = SHUTDOWN_LEN_RST;
      settings_used   = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Standby: every non-star key disarms, two stars open entry.
      send_key(KEY_OTHER, 1'b0);
      send_key(KEY_STAR, 1'b1);
      send_key(4'd4, 1'b0);
      send_key(KEY_STAR, 1'b0);
      send_key(KEY_CONFIRM, 1'b1);
      send_key(KEY_STAR, 1'b1);
      send_key(KEY_OTHER_MAX, 1'b1);
      send_key(KEY_STAR, 1'b0);
      send_key(KEY_STAR, 1'b1);

      // Entry: delete and enter on an empty entry, then the default photo
      // code with an extra digit on a full entry and a correction.
      send_key(KEY_STAR, 1'b0);
      send_key(KEY_CONFIRM, 1'b0);
      type_digits(PHOTO_CODE_RST, CODE_NIBS, 1'b0);
      send_key(4'd3, 1'b1);
      send_key(KEY_STAR, 1'b0);
      send_key(PHOTO_CODE_RST[3:0], 1'b0);
      send_key(KEY_CONFIRM, 1'b1);

      // Photo view ignores everything but star.
      send_key(4'd7, 1'b1);
      send_key(KEY_CONFIRM, 1'b1);
      send_key(KEY_STAR, 1'b0);

      random_phase(PHASE_KEYS);

      // Shortest all-zero code, longest all-nine code, zero length.
      program_codes('0, 4'd1, 40'h9999999999, 4'd10, random_digits(), 4'd0);
      hold_go = 1'b1;
      random_phase(PHASE_KEYS);

      // Three equal codes pulse together.
      codes[UNLOCK] = random_digits();
      program_codes(codes[UNLOCK], 4'd4, codes[UNLOCK], 4'd4, codes[UNLOCK], 4'd4);
      random_phase(PHASE_KEYS);

      // Lengths beyond the entry depth never match; a full-length code does.
      program_codes('1, 4'd15, random_digits(), 4'd11, random_digits(), 4'd10);
      random_phase(PHASE_KEYS);

      program_codes(random_digits(), 4'($urandom_range(1, 10)),
                    random_digits(), 4'($urandom_range(1, 10)),
                    random_digits(), 4'($urandom_range(1, 10)));
      random_phase(PHASE_KEYS);

      // Final stretch at full rate on both sides.
      program_codes(random_digits(), 4'($urandom_range(1, 10)),
                    random_digits(), 4'($urandom_range(1, 10)),
                    random_digits(), 4'($urandom_range(1, 10)));
      quiet_tail = 1'b1;
      random_phase(PHASE_KEYS);

      drain();
      repeat (8) @(posedge clock);

      $display("Run covered %0d keys under %0d code settings, with a long result hold-off.",
               keys_sent, settings_used);
      $display("Results checked: %0d; unlock %0d, capture %0d, shutdown %0d, photo views %0d.",
               results_seen, unlock_hits, capture_hits, shutdown_hits, view_entries);
      if (fail_count == 0)
         $display("keypad_code_lock test passed");
      else
         $display("keypad_code_lock test failed");
      $finish;
   end

endmodule
